@@ rtl/core/tlbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbp_pkg: two-level local branch predictor package
// Shared sizes, command codes and counter constants.
// ----------------------------------------------------------------------------
package tlbp_pkg;

   // default table sizes
   localparam int HISTORY_ENTRIES_DEF = 512;
   localparam int PATTERN_ROWS_DEF    = 64;
   localparam int PATTERN_COLUMNS_DEF = 8;

   // history slot comes from pc above the lowest bits
   localparam int PC_COLUMN_SHIFT = 3;
   localparam int PC_WIDTH        = 32;

   // command codes
   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   // two-bit saturating counter
   localparam logic [1:0] COUNTER_MAX   = 2'd3;
   localparam logic [1:0] COUNTER_MIN   = 2'd0;
   localparam logic [1:0] COUNTER_RESET = 2'd1;

endpackage

@@ rtl/core/tlbp_if.sv @@
// ----------------------------------------------------------------------------
// tlbp_req_if / tlbp_rsp_if: predictor channels
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface tlbp_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] branch_pc;
   logic        outcome_taken;

   modport source (output valid, output cmd, output branch_pc, output outcome_taken,
                   input ready);
   modport sink   (input valid, input cmd, input branch_pc, input outcome_taken,
                   output ready);
endinterface

interface tlbp_rsp_if;
   logic valid;
   logic ready;
   logic predict_taken;

   modport source (output valid, output predict_taken, input ready);
   modport sink   (input valid, input predict_taken, output ready);
endinterface

@@ rtl/core/two_level_local_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// two_level_local_branch_predictor: local-history two-level predictor
// Per-address history table feeding a column-by-row table of 2-bit counters.
// ----------------------------------------------------------------------------
// Flow: a predict word is accepted, then the slot reduce, history read and
// counter read steps run in turn before the response is valid; one word in
// flight. Any history or column count that is not a power of two adds a
// reciprocal remainder step to the slot reduce, and a stalled response holds
// the word in its last step. Reset: a clearing pass over max(HISTORY_ENTRIES,
// COLUMNS*ROWS) entries (512 by default), ready low.
// ----------------------------------------------------------------------------
module two_level_local_branch_predictor #(
   parameter int HISTORY_ENTRIES = tlbp_pkg::HISTORY_ENTRIES_DEF,
   parameter int PATTERN_ROWS    = tlbp_pkg::PATTERN_ROWS_DEF,
   parameter int PATTERN_COLUMNS = tlbp_pkg::PATTERN_COLUMNS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tlbp_req_if.sink  req_chan,
   tlbp_rsp_if.source rsp_chan
);

   // sizes
   localparam int HW        = $clog2(HISTORY_ENTRIES);            // history index
   localparam int RW        = $clog2(PATTERN_ROWS);               // history value
   localparam int CW        = (PATTERN_COLUMNS > 1) ? $clog2(PATTERN_COLUMNS) : 1;
   localparam int CNT_DEPTH = PATTERN_COLUMNS * PATTERN_ROWS;
   localparam int CIW       = $clog2(CNT_DEPTH);                  // counter index
   localparam int CLR_DEPTH = (HISTORY_ENTRIES > CNT_DEPTH) ? HISTORY_ENTRIES : CNT_DEPTH;
   localparam int CLW       = $clog2(CLR_DEPTH);
   localparam int SLOT_W    = tlbp_pkg::PC_WIDTH - tlbp_pkg::PC_COLUMN_SHIFT;

   // sequencer codes
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_REDUCE = 3'd2;
   localparam logic [2:0] S_HIST   = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [CLW-1:0] clr_ff, clr_in;

   // captured request word
   logic        cmd_ff, cmd_in;
   logic [31:0] pc_ff, pc_in;
   logic        taken_ff, taken_in;

   logic [CIW-1:0] cidx_ff, cidx_in;
   logic [RW-1:0]  hist_ff, hist_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_taken_ff, rsp_taken_in;

   logic req_fire;
   logic start;

   // slot reduction
   logic          col_done, hslot_done;
   logic [CW-1:0] col;
   logic [HW-1:0] hslot;

   // memories
   logic [RW-1:0] hist_mem [HISTORY_ENTRIES];
   logic [1:0]    cnt_mem  [CNT_DEPTH];
   logic [RW-1:0] hist_rd_ff;
   logic [1:0]    cnt_rd_ff;

   logic          hist_we;
   logic [HW-1:0] hist_waddr;
   logic [RW-1:0] hist_wdata;
   logic          cnt_we;
   logic [CIW-1:0] cnt_waddr;
   logic [1:0]    cnt_wdata;
   logic [CIW-1:0] cnt_raddr;

   // update arithmetic
   logic [RW:0]   hist_shift;
   logic [RW-1:0] hist_next;
   logic [1:0]    cnt_next;
   logic          rsp_stall;
   logic          clr_hist_hit, clr_cnt_hit;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign start          = req_fire;

   // column = pc mod columns, history slot = (pc >> 3) mod entries
   tlbp_mod_unit #(
      .DIVISOR   (PATTERN_COLUMNS),
      .WIDTH     (tlbp_pkg::PC_WIDTH),
      .REM_WIDTH (CW)
   ) u_col_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .value     (pc_ff),
      .done      (col_done),
      .remainder (col)
   );

   tlbp_mod_unit #(
      .DIVISOR   (HISTORY_ENTRIES),
      .WIDTH     (SLOT_W),
      .REM_WIDTH (HW)
   ) u_slot_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .value     (pc_ff[tlbp_pkg::PC_WIDTH-1:tlbp_pkg::PC_COLUMN_SHIFT]),
      .done      (hslot_done),
      .remainder (hslot)
   );

   // counter address: col * rows + history (wraps safely, true value < depth)
   assign cnt_raddr = CIW'(CIW'(col) * CIW'(PATTERN_ROWS)) + CIW'(hist_rd_ff);

   // shift outcome in, keep below rows (value < 2*rows: one compare/subtract)
   assign hist_shift = {hist_ff, taken_ff};
   assign hist_next  = (hist_shift >= (RW + 1)'(PATTERN_ROWS))
                     ? RW'(hist_shift - (RW + 1)'(PATTERN_ROWS))
                     : RW'(hist_shift);

   always_comb begin
      cnt_next = cnt_rd_ff;
      if (taken_ff) begin
         if (cnt_rd_ff != tlbp_pkg::COUNTER_MAX) begin
            cnt_next = cnt_rd_ff + 2'd1;
         end
      end else begin
         if (cnt_rd_ff != tlbp_pkg::COUNTER_MIN) begin
            cnt_next = cnt_rd_ff - 2'd1;
         end
      end
   end

   // a predict response must wait for the output register to drain
   assign rsp_stall = (cmd_ff == tlbp_pkg::CMD_PREDICT) && rsp_valid_ff && !rsp_chan.ready;

   assign clr_hist_hit = ({1'b0, clr_ff} < (CLW + 1)'(HISTORY_ENTRIES));
   assign clr_cnt_hit  = ({1'b0, clr_ff} < (CLW + 1)'(CNT_DEPTH));

   // write port muxing: clearing pass or update write-back
   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = hslot;
      hist_wdata = hist_next;
      cnt_we     = 1'b0;
      cnt_waddr  = cidx_ff;
      cnt_wdata  = cnt_next;
      if (state_ff == S_CLEAR) begin
         hist_we    = clr_hist_hit;
         hist_waddr = clr_ff[HW-1:0];
         hist_wdata = '0;
         cnt_we     = clr_cnt_hit;
         cnt_waddr  = clr_ff[CIW-1:0];
         cnt_wdata  = tlbp_pkg::COUNTER_RESET;
      end else if (state_ff == S_EXEC && cmd_ff == tlbp_pkg::CMD_UPDATE) begin
         hist_we = 1'b1;
         cnt_we  = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      pc_in        = pc_ff;
      taken_in     = taken_ff;
      cidx_in      = cidx_ff;
      hist_in      = hist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_taken_in = rsp_taken_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLW'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_chan.cmd;
               pc_in    = req_chan.branch_pc;
               taken_in = req_chan.outcome_taken;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            // history read issued once both slots are known
            if (col_done && hslot_done) begin
               state_in = S_HIST;
            end
         end
         S_HIST: begin
            // history word is back; counter read issued this cycle
            hist_in  = hist_rd_ff;
            cidx_in  = cnt_raddr;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!rsp_stall) begin
               if (cmd_ff == tlbp_pkg::CMD_PREDICT) begin
                  rsp_valid_in = 1'b1;
                  rsp_taken_in = cnt_rd_ff[1];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      pc_ff        <= pc_in;
      taken_ff     <= taken_in;
      cidx_ff      <= cidx_in;
      hist_ff      <= hist_in;
      rsp_taken_ff <= rsp_taken_in;
   end

   // history table: one write, one registered read
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem[hslot];
   end

   // pattern counters: one write, one registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.predict_taken = rsp_taken_ff;

endmodule

@@ rtl/core/tlbp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// tlbp_mod_unit: remainder by a constant
// Power-of-two divisor: plain mask, always done. Otherwise a reciprocal
// multiply gives the quotient, then one multiply-subtract gives the remainder;
// both are registered, and done stays low until the remainder register is ready.
// ----------------------------------------------------------------------------
module tlbp_mod_unit #(
   parameter int DIVISOR   = 8,
   parameter int WIDTH     = 32,
   parameter int REM_WIDTH = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     value,
   output logic                 done,
   output logic [REM_WIDTH-1:0] remainder
);

   localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

   generate
      if (IS_POW2) begin : g_mask
         assign remainder = value[REM_WIDTH-1:0] & REM_WIDTH'(DIVISOR - 1);
         assign done      = 1'b1;
      end else begin : g_recip
         // floor(x / D) = (x * MAGIC) >> (WIDTH + DL) for every WIDTH-bit x
         localparam int              DL    = $clog2(DIVISOR);
         localparam int              SHIFT = WIDTH + DL;
         localparam longint unsigned MAGIC = ((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1;
         localparam int              PW    = 2 * WIDTH + 2;

         logic [1:0]           phase_ff, phase_in;
         logic [WIDTH-1:0]     quot_ff;
         logic [REM_WIDTH-1:0] rem_ff;
         logic [PW-1:0]        prod;

         // value holds steady from the cycle after start
         assign prod = PW'(value) * PW'(MAGIC);

         always_comb begin
            phase_in = phase_ff;
            if (start) begin
               phase_in = 2'd2;
            end else if (phase_ff != 2'd0) begin
               phase_in = phase_ff - 2'd1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= 2'd0;
            end else begin
               phase_ff <= phase_in;
            end
            quot_ff <= WIDTH'(prod >> SHIFT);
            rem_ff  <= REM_WIDTH'(value - WIDTH'(DIVISOR) * quot_ff);
         end

         assign remainder = rem_ff;
         assign done      = (phase_ff == 2'd0);
      end
   endgenerate

endmodule

@@ rtl/core/tlbp_checker.sv @@
// ----------------------------------------------------------------------------
// tlbp_checker: port-level checks for the predictor
// Watches the request and response handshakes over time.
// ----------------------------------------------------------------------------
module tlbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_predict_taken
);

   // clearing pass follows reset: no word taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // one word in flight: ready drops after each accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while one is in flight");

   // a response only appears out of the busy phase
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while idle");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_predict_taken)))
      else $error("stalled response dropped or changed");

endmodule

bind two_level_local_branch_predictor tlbp_checker u_tlbp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_predict_taken (rsp_chan.predict_taken)
);
